@@ hdl/evc_pkg.sv @@
package evc_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int GAMMA_BITS    = 31;
  localparam int DIM_BITS      = 2;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [DIM_BITS-1:0]   DIM_RESET   = 2'd3;
  localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 31'd26214;

  typedef enum logic [1:0] {
    CMD_P2C  = 2'd0,
    CMD_C2P  = 2'd1,
    CMD_PRES = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DENS = 2'd1,
    ST_DIM1 = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DIM   = 2'd0,
    REG_GAMMA = 2'd1
  } reg_e;

  // per-stage flags carried along the divider pipeline
  typedef struct packed {
    logic neg;   // quotient sign
    logic sa;    // numerator sign
    logic za;    // numerator zero
    logic zd;    // divisor zero
  } div_side_t;

endpackage

@@ hdl/evc_if.sv @@
interface evc_in_if #(
  parameter int W = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic signed [W-1:0]  density;
  logic signed [W-1:0]  comp_x;
  logic signed [W-1:0]  comp_y;
  logic signed [W-1:0]  comp_z;
  logic signed [W-1:0]  pressure_or_energy;
  logic                 last_point;

  modport source (
    output valid, command, density, comp_x, comp_y, comp_z, pressure_or_energy, last_point,
    input  ready
  );
  modport sink (
    input  valid, command, density, comp_x, comp_y, comp_z, pressure_or_energy, last_point,
    output ready
  );
endinterface

interface evc_out_if #(
  parameter int W = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [W-1:0]  out_density;
  logic signed [W-1:0]  out_x;
  logic signed [W-1:0]  out_y;
  logic signed [W-1:0]  out_z;
  logic signed [W-1:0]  out_scalar;
  logic [1:0]           status;
  logic                 out_last;

  modport source (
    output valid, out_density, out_x, out_y, out_z, out_scalar, status, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_density, out_x, out_y, out_z, out_scalar, status, out_last,
    output ready
  );
endinterface

interface evc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [evc_pkg::CFG_IDX_BITS-1:0]    index;
  logic [evc_pkg::GAMMA_BITS-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/euler_variable_conversion_unit.sv @@
// Euler variable conversion, one flow point per transaction.
// in_i carries a command and the point's variables; out_o returns one result
// per input transaction, in order. cfg_i writes dimension (index 0) and
// gamma minus one (index 1); it is always ready and should only be used while
// no points are in flight.
// Throughput: one point per cycle while the output is taken or holds no
// result. The pipeline depth is set by the dividers, which resolve one
// quotient bit per pipeline stage over WORD_BITS+FRAC_BITS stages, with
// Q16.16 by default.
// The whole pipeline advances together: while the output holds a result that
// is not taken, in_i.ready is low and every stage holds, so nothing is lost
// or repeated.
// Reset clears all valid bits and loads dimension 3 and gamma minus one 0.4;
// no clearing pass is needed.
module euler_variable_conversion_unit #(
  parameter int WORD_BITS = evc_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = evc_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  evc_in_if.sink     in_i,
  evc_out_if.source  out_o,
  evc_cfg_if.sink    cfg_i
);
  import evc_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int OW   = (W > GAMMA_BITS) ? W : GAMMA_BITS;
  localparam int NW   = W + F;
  localparam int LD   = NW + 2;
  localparam int QI   = 4 + LD;
  localparam int NST  = QI + 7;
  localparam int LAST = NST - 1;

  localparam logic signed [W+1:0] MAXP = (W+2)'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [W+1:0] MINN = -MAXP - (W+2)'(1);

  typedef struct packed {
    cmd_e                   cmd;
    status_e                err;
    logic                   last;
    logic signed [W-1:0]    rho;
    logic signed [W-1:0]    e;
    logic signed [W-1:0]    s;
    logic signed [W-1:0]    q;
    logic [2:0][W-1:0]      vec;
    logic                   sat;
  } stage_t;

  logic [DIM_BITS-1:0]   dim_q;
  logic [GAMMA_BITS-1:0] gamma_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= DIM_RESET;
      gamma_q <= GAMMA_RESET;
    end else if (cfg_i.valid) begin
      unique case (reg_e'(cfg_i.index))
        REG_DIM:   dim_q   <= cfg_i.data[DIM_BITS-1:0];
        REG_GAMMA: gamma_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [NST-1:0] v_q;
  stage_t st_q [NST];
  stage_t st_d [NST];

  assign en         = !v_q[LAST] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st_d;
    end
  end

  logic signed [OW-1:0] g_ext;
  assign g_ext = OW'(gamma_q);

  // momentum (rho * c) and squares of the components
  logic signed [W-1:0] rc_p [3];
  logic signed [W-1:0] sq_p [3];
  logic [2:0]          rc_sat, sq_sat;

  for (genvar k = 0; k < 3; k++) begin : g_mul
    evc_mul #(.W(W), .F(F), .OW(OW)) u_rc (
      .clk_i (clk_i), .en_i (en),
      .a_i   (OW'($signed(st_q[0].rho))), .b_i (OW'($signed(st_q[0].vec[k]))),
      .p_o   (rc_p[k]), .sat_o (rc_sat[k])
    );
    evc_mul #(.W(W), .F(F), .OW(OW)) u_sq (
      .clk_i (clk_i), .en_i (en),
      .a_i   (OW'($signed(st_q[0].vec[k]))), .b_i (OW'($signed(st_q[0].vec[k]))),
      .p_o   (sq_p[k]), .sat_o (sq_sat[k])
    );
  end

  // component / rho for conservative to primitive
  logic signed [W-1:0] qc [3];
  logic [2:0]          qc_sat;

  for (genvar k = 0; k < 3; k++) begin : g_div
    evc_div #(.W(W), .F(F), .DW(OW)) u_div (
      .clk_i (clk_i), .en_i (en),
      .num_i ($signed(st_q[3].vec[k])), .den_i (OW'($signed(st_q[3].rho))),
      .q_o   (qc[k]), .sat_o (qc_sat[k])
    );
  end

  // e / g for command 0, s / rho otherwise
  logic signed [W-1:0]  qs_num;
  logic signed [OW-1:0] qs_den;
  logic signed [W-1:0]  qs;
  logic                 qs_sat;

  assign qs_num = (st_q[3].cmd == CMD_P2C) ? st_q[3].e : st_q[3].s;
  assign qs_den = (st_q[3].cmd == CMD_P2C) ? g_ext : OW'($signed(st_q[3].rho));

  evc_div #(.W(W), .F(F), .DW(OW)) u_div_s (
    .clk_i (clk_i), .en_i (en),
    .num_i (qs_num), .den_i (qs_den),
    .q_o   (qs), .sat_o (qs_sat)
  );

  logic signed [W-1:0] rs_p, gx_p;
  logic                rs_sat, gx_sat;

  evc_mul #(.W(W), .F(F), .OW(OW)) u_rs (
    .clk_i (clk_i), .en_i (en),
    .a_i   (OW'($signed(st_q[QI].rho))), .b_i (OW'($signed(st_q[QI].s))),
    .p_o   (rs_p), .sat_o (rs_sat)
  );

  evc_mul #(.W(W), .F(F), .OW(OW)) u_gx (
    .clk_i (clk_i), .en_i (en),
    .a_i   (g_ext), .b_i (OW'($signed(st_q[QI+3].s))),
    .p_o   (gx_p), .sat_o (gx_sat)
  );

  // input decode
  logic [DIM_BITS-1:0] dim_eff;
  cmd_e                in_cmd;
  stage_t              in_st;

  always_comb begin
    dim_eff      = (dim_q == '0) ? DIM_BITS'(1) : dim_q;
    in_cmd       = cmd_e'(in_i.command);
    in_st.cmd    = in_cmd;
    in_st.last   = in_i.last_point;
    in_st.rho    = in_i.density;
    in_st.e      = in_i.pressure_or_energy;
    in_st.s      = '0;
    in_st.q      = '0;
    in_st.sat    = 1'b0;
    in_st.vec[0] = in_i.comp_x;
    in_st.vec[1] = (dim_eff >= DIM_BITS'(2)) ? in_i.comp_y : '0;
    in_st.vec[2] = (dim_eff >= DIM_BITS'(3)) ? in_i.comp_z : '0;
    if (in_cmd == CMD_PRES && dim_eff < DIM_BITS'(2)) begin
      in_st.err = ST_DIM1;
    end else if (in_cmd != CMD_NOP && in_i.density <= 0) begin
      in_st.err = ST_DENS;
    end else begin
      in_st.err = ST_OK;
    end
  end

  logic [W+1:0]        sq_sum;
  logic signed [W:0]   half_q, half_rs;
  logic signed [W-1:0] k_val, t_val;
  logic signed [W+1:0] lhs, rhs, acc;
  logic signed [W-1:0] x_val;
  logic                x_sat, ok, zero_all;
  logic signed [W-1:0] sc_val;
  logic                sat_fin;

  always_comb begin
    st_d[0] = in_st;
    for (int i = 1; i < NST; i++) begin
      st_d[i] = st_q[i-1];
    end

    // products and |c|^2 (squares are never negative)
    sq_sum = (W+2)'(unsigned'(sq_p[0])) + (W+2)'(unsigned'(sq_p[1]))
           + (W+2)'(unsigned'(sq_p[2]));
    if (st_q[2].cmd == CMD_P2C) begin
      st_d[3].vec[0] = rc_p[0];
      st_d[3].vec[1] = rc_p[1];
      st_d[3].vec[2] = rc_p[2];
    end
    if ($signed(sq_sum) > MAXP) begin
      st_d[3].s = MAXP[W-1:0];
    end else begin
      st_d[3].s = sq_sum[W-1:0];
    end
    st_d[3].sat = st_q[2].sat
                | ((st_q[2].cmd == CMD_P2C) && (rc_sat != '0))
                | ((st_q[2].cmd != CMD_NOP) && ((sq_sat != '0) || ($signed(sq_sum) > MAXP)));

    // divider results
    if (st_q[QI-1].cmd == CMD_C2P) begin
      st_d[QI].vec[0] = qc[0];
      st_d[QI].vec[1] = qc[1];
      st_d[QI].vec[2] = qc[2];
    end
    st_d[QI].q   = qs;
    st_d[QI].sat = st_q[QI-1].sat
                 | ((st_q[QI-1].cmd == CMD_C2P) && (qc_sat != '0))
                 | ((st_q[QI-1].cmd != CMD_NOP) && qs_sat);

    // kinetic term halved, truncating toward zero
    half_q = {st_q[QI].q[W-1], st_q[QI].q} + (W+1)'(st_q[QI].q[W-1]);
    k_val  = half_q[W:1];
    if (st_q[QI].cmd != CMD_P2C) begin
      st_d[QI+1].q = k_val;
    end

    // energy sum or e - k, saturated
    half_rs = {rs_p[W-1], rs_p} + (W+1)'(rs_p[W-1]);
    t_val   = half_rs[W:1];
    if (st_q[QI+2].cmd == CMD_P2C) begin
      lhs = (W+2)'(st_q[QI+2].q);
      rhs = (W+2)'(t_val);
    end else begin
      lhs = (W+2)'(st_q[QI+2].e);
      rhs = -(W+2)'(st_q[QI+2].q);
    end
    acc = lhs + rhs;
    if (acc > MAXP) begin
      x_val = MAXP[W-1:0];
      x_sat = 1'b1;
    end else if (acc < MINN) begin
      x_val = MINN[W-1:0];
      x_sat = 1'b1;
    end else begin
      x_val = acc[W-1:0];
      x_sat = 1'b0;
    end
    st_d[QI+3].s   = x_val;
    st_d[QI+3].sat = st_q[QI+2].sat
                   | ((st_q[QI+2].cmd == CMD_P2C) && rs_sat)
                   | ((st_q[QI+2].cmd != CMD_NOP) && x_sat);

    // final select, errors clear every value field
    sc_val   = (st_q[LAST-1].cmd == CMD_P2C) ? st_q[LAST-1].s : gx_p;
    sat_fin  = st_q[LAST-1].sat
             | (((st_q[LAST-1].cmd == CMD_C2P) || (st_q[LAST-1].cmd == CMD_PRES)) && gx_sat);
    ok       = st_q[LAST-1].err == ST_OK;
    zero_all = !ok || (st_q[LAST-1].cmd == CMD_NOP);
    st_d[LAST].s = zero_all ? '0 : sc_val;
    if (zero_all || st_q[LAST-1].cmd == CMD_PRES) begin
      st_d[LAST].rho = '0;
      st_d[LAST].vec = '0;
    end
    if (ok) begin
      st_d[LAST].err = sat_fin ? ST_SAT : ST_OK;
    end
  end

  assign out_o.valid       = v_q[LAST];
  assign out_o.out_density = st_q[LAST].rho;
  assign out_o.out_x       = st_q[LAST].vec[0];
  assign out_o.out_y       = st_q[LAST].vec[1];
  assign out_o.out_z       = st_q[LAST].vec[2];
  assign out_o.out_scalar  = st_q[LAST].s;
  assign out_o.status      = st_q[LAST].err;
  assign out_o.out_last    = st_q[LAST].last;

endmodule

@@ hdl/evc_mul.sv @@
module evc_mul #(
  parameter int W  = evc_pkg::WORD_BITS_DEF,
  parameter int F  = evc_pkg::FRAC_BITS_DEF,
  parameter int OW = evc_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [OW-1:0] a_i,
  input  logic signed [OW-1:0] b_i,
  output logic signed [W-1:0]  p_o,
  output logic                 sat_o
);
  localparam int PW = 2 * OW;

  logic [OW-1:0] ma, mb;
  logic [PW-1:0] prod_q;
  logic          neg_q;
  logic [PW-1:0] sh, lim, mg;
  logic          sat_d;
  logic [W-1:0]  p_d;

  always_comb begin
    ma = a_i[OW-1] ? OW'(-a_i) : OW'(a_i);
    mb = b_i[OW-1] ? OW'(-b_i) : OW'(b_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(ma) * PW'(mb);
      neg_q  <= a_i[OW-1] ^ b_i[OW-1];
    end
  end

  // drop fraction bits, then clamp to the signed word
  always_comb begin
    sh    = prod_q >> F;
    lim   = PW'({1'b0, {(W-1){1'b1}}}) + PW'(neg_q);
    sat_d = sh > lim;
    mg    = sat_d ? lim : sh;
    p_d   = neg_q ? W'(-mg) : W'(mg);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o   <= p_d;
      sat_o <= sat_d;
    end
  end

endmodule

@@ hdl/evc_div.sv @@
module evc_div #(
  parameter int W  = evc_pkg::WORD_BITS_DEF,
  parameter int F  = evc_pkg::FRAC_BITS_DEF,
  parameter int DW = evc_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [W-1:0]  num_i,
  input  logic signed [DW-1:0] den_i,
  output logic signed [W-1:0]  q_o,
  output logic                 sat_o
);
  import evc_pkg::*;

  localparam int NW = W + F;

  logic [W-1:0]  ma;
  logic [DW-1:0] md;

  logic [DW-1:0] rem_q  [NW+1];
  logic [NW-1:0] quo_q  [NW+1];
  logic [NW-1:0] num_q  [NW+1];
  logic [DW-1:0] d_q    [NW+1];
  div_side_t     side_q [NW+1];

  always_comb begin
    ma = num_i[W-1] ? W'(-num_i) : W'(num_i);
    md = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      quo_q[0]  <= '0;
      num_q[0]  <= {ma, {F{1'b0}}};
      d_q[0]    <= md;
      side_q[0] <= '{neg: num_i[W-1] ^ den_i[DW-1], sa: num_i[W-1],
                     za: (ma == '0), zd: (md == '0)};
    end
  end

  // one restoring step per stage, numerator MSB first
  for (genvar j = 0; j < NW; j++) begin : g_step
    logic [DW:0] rsh, diff;
    logic        ge;

    assign rsh  = {rem_q[j], num_q[j][NW-1]};
    assign ge   = rsh >= {1'b0, d_q[j]};
    assign diff = rsh - {1'b0, d_q[j]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= ge ? diff[DW-1:0] : rsh[DW-1:0];
        quo_q[j+1]  <= {quo_q[j][NW-2:0], ge};
        num_q[j+1]  <= num_q[j] << 1;
        d_q[j+1]    <= d_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  logic          sgn, over, sat_d;
  logic [NW-1:0] lim, mg;
  logic [W-1:0]  q_d;

  // zero divisor goes to the extreme with the numerator's sign
  always_comb begin
    sgn   = side_q[NW].zd ? side_q[NW].sa : side_q[NW].neg;
    lim   = NW'({1'b0, {(W-1){1'b1}}}) + NW'(sgn);
    over  = quo_q[NW] > lim;
    mg    = (side_q[NW].zd || over) ? lim : quo_q[NW];
    sat_d = !side_q[NW].za && (side_q[NW].zd || over);
    if (side_q[NW].za) begin
      q_d = '0;
    end else begin
      q_d = sgn ? W'(-mg) : W'(mg);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o   <= q_d;
      sat_o <= sat_d;
    end
  end

endmodule

@@ tb/euler_variable_conversion_unit_test.sv @@
`timescale 1ns / 1ps

module euler_variable_conversion_unit_test;
  import evc_pkg::*;

  localparam int W = 32;
  localparam int FB = 16;
  localparam int LATENCY = W + FB + 12;
  localparam longint MAXP = 64'sd2147483647;
  localparam longint MINN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    cmd_e            cmd;
    logic [W-1:0]    rho, cx, cy, cz, pe;
    logic            last;
  } point_t;

  typedef struct packed {
    logic [W-1:0] rho, x, y, z, scalar;
    status_e      st;
    logic         last;
  } conv_t;

  typedef struct {
    point_t p;
    logic   typed;   // expectation typed in the table
    conv_t  r;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  evc_in_if  #(.W(W)) in_if ();
  evc_out_if #(.W(W)) out_if ();
  evc_cfg_if          cfg_if ();

  euler_variable_conversion_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  int unsigned dim_reg;
  longint      gamma_reg;
  bit          sat_seen;
  conv_t       pending_q[$];
  int          errors = 0;
  int          cycles = 0;
  bit          long_hold = 1'b0;
  bit          stim_done = 1'b0;

  // ---------------- predictor ----------------
  function automatic longint sat_word(longint v);
    if (v > MAXP) begin
      sat_seen = 1'b1;
      return MAXP;
    end
    if (v < MINN) begin
      sat_seen = 1'b1;
      return MINN;
    end
    return v;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    if (p < 0) p = -((-p) >>> FB);
    else p = p >>> FB;
    if (p > 128'(MAXP)) begin
      sat_seen = 1'b1;
      return MAXP;
    end
    if (p < 128'(MINN)) begin
      sat_seen = 1'b1;
      return MINN;
    end
    return longint'(p);
  endfunction

  function automatic longint q_div(longint a, longint b);
    logic signed [127:0] n, q;
    if (a == 0) return 0;
    if (b == 0) begin
      sat_seen = 1'b1;
      return (a < 0) ? MINN : MAXP;
    end
    n = 128'(a) <<< FB;
    q = n / 128'(b);   // truncates toward zero
    if (q > 128'(MAXP)) begin
      sat_seen = 1'b1;
      return MAXP;
    end
    if (q < 128'(MINN)) begin
      sat_seen = 1'b1;
      return MINN;
    end
    return longint'(q);
  endfunction

  function automatic longint sq_norm(longint c[3]);
    longint s;
    s = q_mul(c[0], c[0]);
    s = sat_word(s + q_mul(c[1], c[1]));
    return sat_word(s + q_mul(c[2], c[2]));
  endfunction

  function automatic longint pressure_from(longint rho, longint m[3], longint e);
    longint k;
    k = q_div(sq_norm(m), rho) / 2;
    return q_mul(gamma_reg, sat_word(e - k));
  endfunction

  function automatic conv_t convert_point(point_t p);
    conv_t r;
    longint rho, e, c[3], v[5];
    int unsigned d;
    d = (dim_reg == 0) ? 1 : dim_reg;
    rho = longint'($signed(p.rho));
    e = longint'($signed(p.pe));
    c[0] = longint'($signed(p.cx));
    c[1] = (d >= 2) ? longint'($signed(p.cy)) : 0;
    c[2] = (d >= 3) ? longint'($signed(p.cz)) : 0;
    v = '{0, 0, 0, 0, 0};
    sat_seen = 1'b0;
    r.st = ST_OK;
    if (p.cmd == CMD_PRES && d < 2) begin
      r.st = ST_DIM1;
    end else if (p.cmd != CMD_NOP && rho <= 0) begin
      r.st = ST_DENS;
    end else if (p.cmd == CMD_P2C) begin
      v[0] = rho;
      for (int i = 0; i < 3; i++) v[i+1] = q_mul(rho, c[i]);
      v[4] = sat_word(q_div(e, gamma_reg) + q_mul(rho, sq_norm(c)) / 2);
    end else if (p.cmd == CMD_C2P) begin
      v[0] = rho;
      for (int i = 0; i < 3; i++) v[i+1] = q_div(c[i], rho);
      v[4] = pressure_from(rho, c, e);
    end else if (p.cmd == CMD_PRES) begin
      v[4] = pressure_from(rho, c, e);
    end
    if (r.st == ST_OK && sat_seen) r.st = ST_SAT;
    r.rho = v[0][W-1:0];
    r.x = v[1][W-1:0];
    r.y = v[2][W-1:0];
    r.z = v[3][W-1:0];
    r.scalar = v[4][W-1:0];
    r.last = p.last;
    return r;
  endfunction

  // ---------------- driving ----------------
  initial begin
    in_if.valid = 1'b0;
    in_if.command = '0;
    in_if.density = '0;
    in_if.comp_x = '0;
    in_if.comp_y = '0;
    in_if.comp_z = '0;
    in_if.pressure_or_energy = '0;
    in_if.last_point = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_DIM;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
  end

  task automatic write_reg(reg_e idx, logic [GAMMA_BITS-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_DIM) dim_reg = val[1:0];
    else gamma_reg = longint'(val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Drives one point; caller is at a negedge. Returns at the next negedge.
  task automatic send_point(point_t p, logic typed, conv_t r);
    conv_t pred;
    in_if.valid <= 1'b1;
    in_if.command <= p.cmd;
    in_if.density <= p.rho;
    in_if.comp_x <= p.cx;
    in_if.comp_y <= p.cy;
    in_if.comp_z <= p.cz;
    in_if.pressure_or_energy <= p.pe;
    in_if.last_point <= p.last;
    do @(posedge clk_i); while (!in_if.ready);
    pred = convert_point(p);
    if (typed && pred != r) begin
      $error("typed expectation disagrees with predictor: cmd=%0d", p.cmd);
      errors++;
    end
    pending_q.push_back(typed ? r : pred);
    @(negedge clk_i);
  endtask

  task automatic idle_in();
    in_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  function automatic logic [W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 3));
      3: return -32'($urandom_range(1, 3));
      4: return 32'($urandom_range(0, 32'h3ffff));
      5: return -32'($urandom_range(0, 32'h3ffff));
      default: return $urandom();
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    int k;
    k = $urandom_range(0, 19);
    p.cmd = cmd_e'((k == 0) ? 3 : k % 3);
    p.rho = ($urandom_range(0, 9) == 0) ? rand_word() : 32'($urandom_range(1, 32'h7ffff));
    p.cx = rand_word();
    p.cy = rand_word();
    p.cz = rand_word();
    p.pe = rand_word();
    p.last = 1'($urandom_range(0, 1));
    return p;
  endfunction

  function automatic point_t mk(cmd_e c, logic [W-1:0] rho, logic [W-1:0] x,
                                logic [W-1:0] y, logic [W-1:0] z, logic [W-1:0] pe,
                                logic l);
    point_t p;
    p.cmd = c; p.rho = rho; p.cx = x; p.cy = y; p.cz = z; p.pe = pe; p.last = l;
    return p;
  endfunction

  function automatic conv_t zero_res(status_e s, logic l);
    conv_t r;
    r.rho = '0; r.x = '0; r.y = '0; r.z = '0; r.scalar = '0; r.st = s; r.last = l;
    return r;
  endfunction

  initial begin
    row_t tbl[$];
    conv_t r;
    int burst;
    logic [GAMMA_BITS-1:0] gammas[4];

    dim_reg = DIM_RESET;
    gamma_reg = longint'(GAMMA_RESET);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table, reset configuration
    tbl.push_back('{mk(CMD_P2C, 32'h0, 32'h10000, 0, 0, 32'h10000, 1), 1,
                    zero_res(ST_DENS, 1)});
    tbl.push_back('{mk(CMD_C2P, 32'h80000000, 5, 6, 7, 8, 0), 1, zero_res(ST_DENS, 0)});
    tbl.push_back('{mk(CMD_PRES, 32'hffffffff, 5, 6, 7, 8, 1), 1, zero_res(ST_DENS, 1)});
    tbl.push_back('{mk(CMD_NOP, 32'h7fffffff, 1, 2, 3, 4, 1), 1, zero_res(ST_OK, 1)});
    r = zero_res(ST_OK, 0);
    r.rho = 32'h10000; r.x = 32'h10000; r.y = 32'h20000; r.z = 32'h30000;
    r.scalar = 32'h7000;
    // rho 1, u (1,2,3), p 0 -> E = 7
    r.scalar = 32'h70000;
    tbl.push_back('{mk(CMD_P2C, 32'h10000, 32'h10000, 32'h20000, 32'h30000, 0, 0), 1, r});
    tbl.push_back('{mk(CMD_P2C, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                       32'h7fffffff, 1), 0, r});
    tbl.push_back('{mk(CMD_C2P, 32'h1, 32'h7fffffff, 32'h80000000, 1, 32'h80000000, 0), 0, r});
    tbl.push_back('{mk(CMD_C2P, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                       32'h7fffffff, 1), 0, r});
    tbl.push_back('{mk(CMD_PRES, 32'h10000, 32'h30000, 32'h40000, 0, 32'h100000, 0), 0, r});
    tbl.push_back('{mk(CMD_PRES, 32'h1, 32'hffffffff, 0, 0, 32'h80000000, 1), 0, r});
    tbl.push_back('{mk(CMD_C2P, 32'h20000, 32'h0, 32'hfffe0000, 32'h10000, 32'h50000, 0), 0, r});
    foreach (tbl[i]) send_point(tbl[i].p, tbl[i].typed, tbl[i].r);
    idle_in();
    drain();

    // one-dimensional case and pressure error, then zero dimension, zero gamma
    write_reg(REG_DIM, 1);
    send_point(mk(CMD_PRES, 32'h10000, 1, 2, 3, 4, 1), 1, zero_res(ST_DIM1, 1));
    send_point(mk(CMD_PRES, 32'h0, 1, 2, 3, 4, 0), 1, zero_res(ST_DIM1, 0));
    send_point(mk(CMD_P2C, 32'h10000, 32'h20000, 32'h7fffffff, 32'h7fffffff, 32'h10000, 0),
               0, r);
    send_point(mk(CMD_C2P, 32'h20000, 32'h20000, 32'h7fffffff, 32'h7fffffff, 32'h10000, 1),
               0, r);
    idle_in();
    drain();
    write_reg(REG_DIM, 0);
    write_reg(REG_GAMMA, 0);
    send_point(mk(CMD_P2C, 32'h10000, 32'h10000, 5, 5, 32'h10000, 0), 0, r);
    send_point(mk(CMD_P2C, 32'h10000, 32'h10000, 5, 5, 32'hffff0000, 0), 0, r);
    send_point(mk(CMD_P2C, 32'h10000, 32'h0, 5, 5, 32'h0, 1), 0, r);
    send_point(mk(CMD_PRES, 32'h10000, 1, 2, 3, 4, 1), 1, zero_res(ST_DIM1, 1));
    idle_in();
    drain();

    gammas[0] = 31'd1;
    gammas[1] = 31'h7fffffff;
    gammas[2] = GAMMA_RESET;
    gammas[3] = 31'd43690;
    // random phases over several settings; long output hold in phase 1,
    // full pause until drained between phases
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_DIM, 2'(ph % 4));
      write_reg(REG_GAMMA, (ph < 4) ? gammas[ph] : 31'($urandom()));
      if (ph == 1) long_hold = 1'b1;
      for (int n = 0; n < 250; n += burst) begin
        burst = $urandom_range(1, 40);
        for (int b = 0; b < burst; b++) send_point(rand_point(), 0, r);
        if ($urandom_range(0, 2) != 0) begin
          idle_in();
          repeat ($urandom_range(1, 12)) @(negedge clk_i);
        end
      end
      idle_in();
      drain();
    end
    stim_done = 1'b1;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_if.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        long_hold = 1'b0;
      end
      mode = (cycles / 500) % 3;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ((cycles % 7) < 3);
      endcase
    end
  end

  // result checking
  always @(posedge clk_i) begin
    conv_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_if.out_density !== e.rho) begin
          $error("out_density exp %h got %h", e.rho, out_if.out_density); errors++;
        end
        if (out_if.out_x !== e.x) begin
          $error("out_x exp %h got %h", e.x, out_if.out_x); errors++;
        end
        if (out_if.out_y !== e.y) begin
          $error("out_y exp %h got %h", e.y, out_if.out_y); errors++;
        end
        if (out_if.out_z !== e.z) begin
          $error("out_z exp %h got %h", e.z, out_if.out_z); errors++;
        end
        if (out_if.out_scalar !== e.scalar) begin
          $error("out_scalar exp %h got %h", e.scalar, out_if.out_scalar); errors++;
        end
        if (out_if.status !== e.st) begin
          $error("status exp %0d got %0d", e.st, out_if.status); errors++;
        end
        if (out_if.out_last !== e.last) begin
          $error("out_last exp %0d got %0d", e.last, out_if.out_last); errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done || cycles >= CYCLE_LIMIT);
    if (!stim_done) begin
      $display("** euler_variable_conversion_unit: FAILED **");
    end else if (errors == 0 && pending_q.size() == 0) begin
      $display("** euler_variable_conversion_unit: PASSED **");
    end else begin
      $display("** euler_variable_conversion_unit: FAILED **");
    end
    $finish;
  end

endmodule
